// ===== design/lav_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lav_pkg: shared types and helpers for the look-at view matrix block
// Fixed-point types, job and matrix records, state encoding and the
// operand tables of the shared multiply-accumulate sequence.
// ============================================================================
package lav_pkg;

    localparam int FRAC_BITS = 16;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [32:0] diff_t;
    typedef logic signed [17:0] unit_t;
    typedef logic signed [19:0] vcomp_t;
    typedef logic signed [63:0] wide_t;
    typedef logic signed [32:0] mop_t;

    typedef struct packed {
        q16_t  [2:0] eye;
        diff_t [2:0] nr;
        q16_t  [2:0] up;
    } job_t;

    typedef struct packed {
        q16_t [2:0] u;
        q16_t [2:0] v;
        q16_t [2:0] n;
        q16_t [2:0] t;
        logic       deg;
    } mat_t;

    typedef struct packed {
        logic [1:0] ia;
        logic [1:0] ib;
        logic [1:0] dst;
        logic       sub;
    } mac_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABS,
        ST_SCALE,
        ST_SQ,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_CROSS_U,
        ST_CROSS_V,
        ST_ROUND_V,
        ST_DOT,
        ST_ROUND_T,
        ST_DONE
    } back_state_t;

    localparam logic [49:0] NORM_LO     = 50'd1 << 29;
    localparam logic [49:0] NORM_HI     = 50'd1 << 30;
    localparam logic [63:0] SQRT_B_INIT = 64'd1 << 62;
    localparam q16_t        ONE_Q16     = 32'sh0001_0000;
    localparam logic [1:0]  ROW_LAST    = 2'd3;
    localparam logic [1:0]  COMP_LAST   = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [4:0] MAC_SQ_N    = 5'd3;
    localparam logic [4:0] MAC_CROSS_N = 5'd6;
    localparam logic [4:0] MAC_DOT_N   = 5'd9;
    localparam logic [4:0] SQRT_LAST   = 5'd31;
    localparam logic [4:0] DIV_LAST    = 5'd16;

    // r[d] = a[d+1]*b[d+2] - a[d+2]*b[d+1]
    function automatic mac_sel_t cross_sel(input logic [3:0] k);
        mac_sel_t s;
        s = '0;
        unique case (k)
            4'd0:    s = '{ia: 2'd1, ib: 2'd2, dst: 2'd0, sub: 1'b0};
            4'd1:    s = '{ia: 2'd2, ib: 2'd1, dst: 2'd0, sub: 1'b1};
            4'd2:    s = '{ia: 2'd2, ib: 2'd0, dst: 2'd1, sub: 1'b0};
            4'd3:    s = '{ia: 2'd0, ib: 2'd2, dst: 2'd1, sub: 1'b1};
            4'd4:    s = '{ia: 2'd0, ib: 2'd1, dst: 2'd2, sub: 1'b0};
            4'd5:    s = '{ia: 2'd1, ib: 2'd0, dst: 2'd2, sub: 1'b1};
            default: s = '0;
        endcase
        return s;
    endfunction

    // dot products E.u, E.v, E.n, three terms each
    function automatic mac_sel_t dot_sel(input logic [3:0] k);
        mac_sel_t s;
        s = '0;
        unique case (k)
            4'd0:    s = '{ia: 2'd0, ib: 2'd0, dst: 2'd0, sub: 1'b0};
            4'd1:    s = '{ia: 2'd1, ib: 2'd1, dst: 2'd0, sub: 1'b0};
            4'd2:    s = '{ia: 2'd2, ib: 2'd2, dst: 2'd0, sub: 1'b0};
            4'd3:    s = '{ia: 2'd0, ib: 2'd0, dst: 2'd1, sub: 1'b0};
            4'd4:    s = '{ia: 2'd1, ib: 2'd1, dst: 2'd1, sub: 1'b0};
            4'd5:    s = '{ia: 2'd2, ib: 2'd2, dst: 2'd1, sub: 1'b0};
            4'd6:    s = '{ia: 2'd0, ib: 2'd0, dst: 2'd2, sub: 1'b0};
            4'd7:    s = '{ia: 2'd1, ib: 2'd1, dst: 2'd2, sub: 1'b0};
            4'd8:    s = '{ia: 2'd2, ib: 2'd2, dst: 2'd2, sub: 1'b0};
            default: s = '0;
        endcase
        return s;
    endfunction

    // Q32.32 to Q16.16, half away from zero
    function automatic wide_t round16(input wide_t x);
        logic [63:0] m;
        logic [63:0] r;
        m = x[63] ? 64'(-x) : 64'(x);
        r = (m + 64'd32768) >> FRAC_BITS;
        return x[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic q16_t sat32(input wide_t x);
        q16_t r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== design/look_at_view_matrix.sv =====
`timescale 1ns / 1ps
// ============================================================================
// look_at_view_matrix: look-at view matrix builder, signed Q16.16
// Builds the 4x4 view matrix from eye, reference point and up vector.
// ============================================================================
// Usage:
//   Requests enter on s_t* (eye, target, up, nine Q16.16 words). Each request
//   yields four results on m_t*, rows 0 to 3 in order; tlast marks row 3 and
//   tuser carries the row index and the degenerate flag.
//   Time to row 0 is set by the two normalisations (a shift-to-range, a
//   32-step bit-serial square root and three 17-step bit-serial divisions
//   each) and the shared 33x33 multiplier; a degenerate request finishes
//   sooner. One matrix is made per sequencer pass, and rows leave at one per
//   cycle while the receiver takes them. A two-entry queue plus the intake
//   register hold up to three requests, and the next matrix is computed while
//   the last is still output. Reset clears all handshake state; no request or
//   result is pending after. A stalled receiver holds the current row; the
//   sequencer then waits with its finished matrix, and intake stops once the
//   queue is full.
// ============================================================================
module look_at_view_matrix (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [287:0]  s_tdata,   // eye_x, eye_y, eye_z, target_x..z, up_x..z
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // entry_0, entry_1, entry_2, entry_3
    output logic [2:0]    m_tuser,   // row_index[1:0], degenerate
    output logic          m_tlast
);

    logic          job_vld;
    logic          job_rdy;
    lav_pkg::job_t job;
    logic          q_vld;
    logic          q_pop;
    lav_pkg::job_t q_job;
    logic          mat_vld;
    logic          mat_rdy;
    lav_pkg::mat_t mat;

    lav_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .job_vld  (job_vld),
        .job_rdy  (job_rdy),
        .job      (job)
    );

    lav_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_vld),
        .push_rdy (job_rdy),
        .wr_job   (job),
        .rd_vld   (q_vld),
        .pop      (q_pop),
        .rd_job   (q_job)
    );

    lav_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_vld   (q_vld),
        .q_pop   (q_pop),
        .q_job   (q_job),
        .mat_vld (mat_vld),
        .mat_rdy (mat_rdy),
        .mat     (mat)
    );

    lav_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .mat_vld  (mat_vld),
        .mat_rdy  (mat_rdy),
        .mat      (mat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== design/lav_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lav_front: request intake
// Registers each request, forms the full-precision view direction E - R and
// hands the job to the queue.
// ============================================================================
module lav_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [287:0]  s_tdata,   // eye_x, eye_y, eye_z, target_x..z, up_x..z
    output logic          job_vld,
    input  logic          job_rdy,
    output lav_pkg::job_t job
);

    logic          vld_reg;
    lav_pkg::job_t job_reg;
    lav_pkg::job_t job_next;

    always_comb
    begin
        job_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            job_next.eye[i] = s_tdata[32*i +: 32];
            job_next.up[i]  = s_tdata[192 + 32*i +: 32];
            job_next.nr[i]  = $signed({s_tdata[32*i + 31], s_tdata[32*i +: 32]})
                            - $signed({s_tdata[96 + 32*i + 31], s_tdata[96 + 32*i +: 32]});
        end
    end

    assign s_tready = !vld_reg || job_rdy;
    assign job_vld  = vld_reg;
    assign job      = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            vld_reg <= 1'b1;
        end
        else if (job_rdy)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// ===== design/lav_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lav_queue: job queue
// Two-entry queue between intake and the arithmetic sequencer.
// ============================================================================
module lav_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          push_rdy,
    input  lav_pkg::job_t wr_job,
    output logic          rd_vld,
    input  logic          pop,
    output lav_pkg::job_t rd_job
);

    lav_pkg::job_t                mem_reg [lav_pkg::QUEUE_DEPTH];
    logic [lav_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [lav_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [lav_pkg::QCNT_W-1:0]   cnt_reg;
    logic                         do_push;
    logic                         do_pop;

    assign push_rdy = cnt_reg != lav_pkg::QCNT_W'(lav_pkg::QUEUE_DEPTH);
    assign rd_vld   = cnt_reg != '0;
    assign rd_job   = mem_reg[rd_ptr_reg];
    assign do_push  = push && push_rdy;
    assign do_pop   = pop && rd_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= lav_pkg::QCNT_W'(lav_pkg::QUEUE_DEPTH))
        else $error("queue fill beyond depth");
`endif

endmodule

// ===== design/lav_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lav_back: matrix arithmetic sequencer
// Normalises n and u through a shared multiplier, a bit-serial square root
// and a bit-serial divider, then forms v and the translation column.
// ============================================================================
module lav_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_vld,
    output logic          q_pop,
    input  lav_pkg::job_t q_job,
    output logic          mat_vld,
    input  logic          mat_rdy,
    output lav_pkg::mat_t mat
);

    lav_pkg::back_state_t state_reg, state_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [1:0]           comp_reg, comp_next;
    logic                 which_reg, which_next;
    logic                 pvld_reg;

    lav_pkg::q16_t   eye_reg [3];
    lav_pkg::q16_t   up_reg  [3];
    lav_pkg::unit_t  n_reg   [3];
    lav_pkg::unit_t  u_reg   [3];
    lav_pkg::vcomp_t v_reg   [3];
    lav_pkg::q16_t   t_reg   [3];
    lav_pkg::wide_t  c_reg   [3];
    logic [49:0]     a_reg   [3];
    logic            sg_reg  [3];
    logic            deg_reg;

    logic [63:0] sq_x_reg;
    logic [63:0] sq_r_reg;
    logic [63:0] sq_b_reg;
    logic [31:0] mag_reg;
    logic [32:0] dv_rem_reg;
    logic [16:0] dv_low_reg;
    logic [16:0] dv_q_reg;

    lav_pkg::wide_t prod_reg;
    logic [1:0]     pdst_reg;
    logic           psub_reg;

    logic [49:0]        a_max;
    logic               in_range;
    lav_pkg::mac_sel_t  sel;
    logic [4:0]         mac_n;
    logic               mac_issue;
    lav_pkg::mop_t      mul_a;
    lav_pkg::mop_t      mul_b;
    logic [63:0]        sq_t;
    logic               sq_ge;
    logic [63:0]        sq_r_nx;
    logic [32:0]        dv_t;
    logic               dv_ge;
    logic [16:0]        dv_q_nx;
    lav_pkg::unit_t     dv_val;
    logic [46:0]        dv_num;

    always_comb
    begin
        a_max = a_reg[0];
        if (a_reg[1] > a_max)
        begin
            a_max = a_reg[1];
        end
        if (a_reg[2] > a_max)
        begin
            a_max = a_reg[2];
        end
    end

    assign in_range = (a_max >= lav_pkg::NORM_LO) && (a_max < lav_pkg::NORM_HI);

    assign sq_t    = sq_r_reg + sq_b_reg;
    assign sq_ge   = sq_x_reg >= sq_t;
    assign sq_r_nx = sq_ge ? (sq_r_reg >> 1) + sq_b_reg : sq_r_reg >> 1;

    assign dv_t    = {dv_rem_reg[31:0], dv_low_reg[16]};
    assign dv_ge   = dv_t >= {1'b0, mag_reg};
    assign dv_q_nx = {dv_q_reg[15:0], dv_ge};
    assign dv_val  = sg_reg[comp_reg] ? -$signed({1'b0, dv_q_nx}) : $signed({1'b0, dv_q_nx});
    assign dv_num  = {1'b0, a_reg[comp_reg][29:0], 16'd0} + {16'd0, mag_reg[31:1]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        which_next = which_reg;
        unique case (state_reg)
            lav_pkg::ST_IDLE:
            begin
                if (q_vld)
                begin
                    state_next = lav_pkg::ST_ABS;
                    which_next = 1'b0;
                end
            end
            lav_pkg::ST_ABS:
            begin
                state_next = lav_pkg::ST_SCALE;
            end
            lav_pkg::ST_SCALE:
            begin
                if (a_max == '0)
                begin
                    state_next = lav_pkg::ST_DONE;
                end
                else if (in_range)
                begin
                    state_next = lav_pkg::ST_SQ;
                    cnt_next   = '0;
                end
            end
            lav_pkg::ST_SQ:
            begin
                if (cnt_reg == lav_pkg::MAC_SQ_N)
                begin
                    state_next = lav_pkg::ST_SQRT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            lav_pkg::ST_SQRT:
            begin
                if (cnt_reg == lav_pkg::SQRT_LAST)
                begin
                    state_next = lav_pkg::ST_DIV_INIT;
                    comp_next  = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            lav_pkg::ST_DIV_INIT:
            begin
                state_next = lav_pkg::ST_DIV;
                cnt_next   = '0;
            end
            lav_pkg::ST_DIV:
            begin
                if (cnt_reg == lav_pkg::DIV_LAST)
                begin
                    cnt_next = '0;
                    if (comp_reg == lav_pkg::COMP_LAST)
                    begin
                        state_next = which_reg ? lav_pkg::ST_CROSS_V : lav_pkg::ST_CROSS_U;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = lav_pkg::ST_DIV_INIT;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            lav_pkg::ST_CROSS_U:
            begin
                if (cnt_reg == lav_pkg::MAC_CROSS_N)
                begin
                    state_next = lav_pkg::ST_ABS;
                    which_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            lav_pkg::ST_CROSS_V:
            begin
                if (cnt_reg == lav_pkg::MAC_CROSS_N)
                begin
                    state_next = lav_pkg::ST_ROUND_V;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            lav_pkg::ST_ROUND_V:
            begin
                state_next = lav_pkg::ST_DOT;
                cnt_next   = '0;
            end
            lav_pkg::ST_DOT:
            begin
                if (cnt_reg == lav_pkg::MAC_DOT_N)
                begin
                    state_next = lav_pkg::ST_ROUND_T;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            lav_pkg::ST_ROUND_T:
            begin
                state_next = lav_pkg::ST_DONE;
            end
            lav_pkg::ST_DONE:
            begin
                if (mat_rdy)
                begin
                    state_next = lav_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lav_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs and multiplier operands
    always_comb
    begin
        sel   = '0;
        mac_n = '0;
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            lav_pkg::ST_SQ:
            begin
                sel   = '{ia: cnt_reg[1:0], ib: cnt_reg[1:0], dst: 2'd0, sub: 1'b0};
                mac_n = lav_pkg::MAC_SQ_N;
                mul_a = $signed({3'd0, a_reg[sel.ia][29:0]});
                mul_b = $signed({3'd0, a_reg[sel.ib][29:0]});
            end
            lav_pkg::ST_CROSS_U:
            begin
                sel   = lav_pkg::cross_sel(cnt_reg[3:0]);
                mac_n = lav_pkg::MAC_CROSS_N;
                mul_a = 33'(up_reg[sel.ia]);
                mul_b = 33'(n_reg[sel.ib]);
            end
            lav_pkg::ST_CROSS_V:
            begin
                sel   = lav_pkg::cross_sel(cnt_reg[3:0]);
                mac_n = lav_pkg::MAC_CROSS_N;
                mul_a = 33'(n_reg[sel.ia]);
                mul_b = 33'(u_reg[sel.ib]);
            end
            lav_pkg::ST_DOT:
            begin
                sel   = lav_pkg::dot_sel(cnt_reg[3:0]);
                mac_n = lav_pkg::MAC_DOT_N;
                mul_a = 33'(eye_reg[sel.ia]);
                unique case (sel.dst)
                    2'd0:    mul_b = 33'(u_reg[sel.ib]);
                    2'd1:    mul_b = 33'(v_reg[sel.ib]);
                    default: mul_b = 33'(n_reg[sel.ib]);
                endcase
            end
            default:
            begin
                sel = '0;
            end
        endcase
    end

    assign mac_issue = cnt_reg < mac_n;
    assign q_pop     = (state_reg == lav_pkg::ST_IDLE) && q_vld;
    assign mat_vld   = state_reg == lav_pkg::ST_DONE;

    always_comb
    begin
        mat     = '0;
        mat.deg = deg_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (!deg_reg)
            begin
                mat.u[i] = 32'(u_reg[i]);
                mat.v[i] = 32'(v_reg[i]);
                mat.n[i] = 32'(n_reg[i]);
                mat.t[i] = t_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lav_pkg::ST_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            which_reg <= 1'b0;
            pvld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            which_reg <= which_next;
            pvld_reg  <= mac_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a * mul_b);
        pdst_reg <= sel.dst;
        psub_reg <= sel.sub;
        unique case (state_reg)
            lav_pkg::ST_IDLE:
            begin
                if (q_vld)
                begin
                    deg_reg <= 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        eye_reg[i] <= $signed(q_job.eye[i]);
                        up_reg[i]  <= $signed(q_job.up[i]);
                        c_reg[i]   <= 64'($signed(q_job.nr[i]));
                    end
                end
            end
            lav_pkg::ST_ABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    a_reg[i]  <= c_reg[i][63] ? 50'(-c_reg[i]) : 50'(c_reg[i]);
                    sg_reg[i] <= c_reg[i][63];
                end
            end
            lav_pkg::ST_SCALE:
            begin
                if (a_max == '0)
                begin
                    deg_reg <= 1'b1;
                end
                else if (a_max >= lav_pkg::NORM_HI)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        a_reg[i] <= a_reg[i] >> 1;
                    end
                end
                else if (a_max < lav_pkg::NORM_LO)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        a_reg[i] <= a_reg[i] << 1;
                    end
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        c_reg[i] <= '0;
                    end
                end
            end
            lav_pkg::ST_SQ:
            begin
                // last square lands in the accumulator on this same edge
                if (cnt_reg == lav_pkg::MAC_SQ_N)
                begin
                    sq_x_reg <= 64'(c_reg[0] + prod_reg);
                    sq_r_reg <= '0;
                    sq_b_reg <= lav_pkg::SQRT_B_INIT;
                end
            end
            lav_pkg::ST_SQRT:
            begin
                sq_x_reg <= sq_ge ? sq_x_reg - sq_t : sq_x_reg;
                sq_r_reg <= sq_r_nx;
                sq_b_reg <= sq_b_reg >> 2;
                if (cnt_reg == lav_pkg::SQRT_LAST)
                begin
                    mag_reg <= sq_r_nx[31:0];
                end
            end
            lav_pkg::ST_DIV_INIT:
            begin
                dv_rem_reg <= {3'd0, dv_num[46:17]};
                dv_low_reg <= dv_num[16:0];
                dv_q_reg   <= '0;
            end
            lav_pkg::ST_DIV:
            begin
                dv_rem_reg <= dv_ge ? dv_t - {1'b0, mag_reg} : dv_t;
                dv_low_reg <= {dv_low_reg[15:0], 1'b0};
                dv_q_reg   <= dv_q_nx;
                if (cnt_reg == lav_pkg::DIV_LAST)
                begin
                    if (which_reg)
                    begin
                        u_reg[comp_reg] <= dv_val;
                    end
                    else
                    begin
                        n_reg[comp_reg] <= dv_val;
                    end
                    if (comp_reg == lav_pkg::COMP_LAST)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            c_reg[i] <= '0;
                        end
                    end
                end
            end
            lav_pkg::ST_ROUND_V:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    v_reg[i] <= 20'(lav_pkg::round16(c_reg[i]));
                    c_reg[i] <= '0;
                end
            end
            lav_pkg::ST_ROUND_T:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    t_reg[i] <= lav_pkg::sat32(-lav_pkg::round16(c_reg[i]));
                end
            end
            default:
            begin
            end
        endcase
        if (pvld_reg)
        begin
            c_reg[pdst_reg] <= psub_reg ? c_reg[pdst_reg] - prod_reg
                                        : c_reg[pdst_reg] + prod_reg;
        end
    end

`ifndef SYNTHESIS
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lav_pkg::ST_DIV |-> dv_rem_reg < {1'b0, mag_reg})
        else $error("divider remainder not below divisor");

    a_scaled: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lav_pkg::ST_SQ |-> in_range)
        else $error("squares taken on unscaled vector");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lav_pkg::ST_DONE && !mat_rdy |=> state_reg == lav_pkg::ST_DONE)
        else $error("matrix dropped before hand-over");
`endif

endmodule

// ===== design/lav_emit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lav_emit: row output stage
// Holds one finished matrix and sends it out as four row results.
// ============================================================================
module lav_emit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          mat_vld,
    output logic          mat_rdy,
    input  lav_pkg::mat_t mat,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // entry_0, entry_1, entry_2, entry_3
    output logic [2:0]    m_tuser,   // row_index[1:0], degenerate
    output logic          m_tlast
);

    logic          busy_reg;
    logic [1:0]    row_reg;
    lav_pkg::mat_t mat_reg;
    logic          take;
    lav_pkg::q16_t one_val;

    assign take     = busy_reg && m_tready;
    assign mat_rdy  = !busy_reg || (m_tready && row_reg == lav_pkg::ROW_LAST);
    assign m_tvalid = busy_reg;
    assign m_tlast  = row_reg == lav_pkg::ROW_LAST;
    assign m_tuser  = {mat_reg.deg, row_reg};
    assign one_val  = mat_reg.deg ? '0 : lav_pkg::ONE_Q16;

    always_comb
    begin
        unique case (row_reg)
            2'd0:    m_tdata = {mat_reg.t[0], mat_reg.u[2], mat_reg.u[1], mat_reg.u[0]};
            2'd1:    m_tdata = {mat_reg.t[1], mat_reg.v[2], mat_reg.v[1], mat_reg.v[0]};
            2'd2:    m_tdata = {mat_reg.t[2], mat_reg.n[2], mat_reg.n[1], mat_reg.n[0]};
            default: m_tdata = {one_val, 96'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end
        else if (mat_vld && mat_rdy)
        begin
            busy_reg <= 1'b1;
            row_reg  <= '0;
        end
        else if (take)
        begin
            if (row_reg == lav_pkg::ROW_LAST)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                row_reg <= row_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mat_vld && mat_rdy)
        begin
            mat_reg <= mat;
        end
    end

`ifndef SYNTHESIS
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        take && row_reg != lav_pkg::ROW_LAST |=> busy_reg && row_reg == $past(row_reg) + 2'd1)
        else $error("row sequence broken");
`endif

endmodule
